/* rtl/hbcd_pkg.sv */
// Shared types, codes and helper functions of the HTTP body chunked decoder.
// Used by hbcd_step and by the top level http_body_chunked_decoder.
package hbcd_pkg;

  localparam int SIZE_BITS  = 32;
  localparam int COUNT_BITS = 24;
  localparam int CFG_W      = 24;
  localparam int CFG_IDX_W  = 2;

  // Largest accepted content length in fixed length framing
  localparam logic [COUNT_BITS-1:0] BODY_CAP = COUNT_BITS'(10485760);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Byte codes used by the size line and trailer checks
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAMING_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BODY_LEN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_OUTPUT   = 2'd2;

  // Framing modes
  localparam logic [1:0] MODE_NONE     = 2'd0;
  localparam logic [1:0] MODE_LENGTH   = 2'd1;
  localparam logic [1:0] MODE_CHUNKED  = 2'd2;
  localparam logic [1:0] MODE_RESERVED = 2'd3;

  // Status codes
  localparam logic [1:0] STAT_MORE     = 2'd0;
  localparam logic [1:0] STAT_COMPLETE = 2'd1;
  localparam logic [1:0] STAT_ERROR    = 2'd2;
  localparam logic [1:0] STAT_NOFRAME  = 2'd3;

  // Parser states, one-hot
  typedef enum logic [10:0] {
    PS_SIZE        = 11'b000_0000_0001,
    PS_EXT         = 11'b000_0000_0010,
    PS_SIZE_LF     = 11'b000_0000_0100,
    PS_DATA        = 11'b000_0000_1000,
    PS_DATA_END    = 11'b000_0001_0000,
    PS_TR_START    = 11'b000_0010_0000,
    PS_TR_LINE     = 11'b000_0100_0000,
    PS_TR_LF       = 11'b000_1000_0000,
    PS_TR_FINAL_LF = 11'b001_0000_0000,
    PS_DONE        = 11'b010_0000_0000,
    PS_ERR         = 11'b100_0000_0000
  } pstate_t;

  typedef struct packed {
    pstate_t               ps;
    logic [SIZE_BITS-1:0]  size_acc;
    logic [SIZE_BITS-1:0]  chunk_left;
    logic [COUNT_BITS-1:0] consumed;
    logic [COUNT_BITS-1:0] emitted;
  } parser_t;

  typedef struct packed {
    logic [1:0]       framing_mode;
    logic [CFG_W-1:0] body_len;
    logic [CFG_W-1:0] max_output;
  } cfg_t;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [1:0] status;
  } result_t;

  // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= "0" && c <= "9") r = {1'b1, 4'(c - 8'h30)};
    else if (c >= "a" && c <= "f") r = {1'b1, 4'(c - 8'h57)};
    else if (c >= "A" && c <= "F") r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  // Legal first byte of a trailer field name
  function automatic logic is_name_start(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           (c >= "0" && c <= "9") || c == "-" || c == "_";
  endfunction

endpackage

/* rtl/hbcd_step.sv */
// Per-byte decode step: next parser state and result for one body byte.
// Depends on hbcd_pkg; purely combinational.
module hbcd_step (
  input  hbcd_pkg::parser_t cur,
  input  hbcd_pkg::cfg_t    cfg,
  input  logic [7:0]        byte_in,
  input  logic              restart,
  output hbcd_pkg::parser_t nxt,
  output hbcd_pkg::result_t res
);
  import hbcd_pkg::*;

  parser_t    s;
  logic [4:0] hex;
  logic [SIZE_BITS-1:0]  left_dec;
  logic [COUNT_BITS-1:0] emit_inc;
  logic [COUNT_BITS-1:0] cons_inc;
  logic       emit;
  logic       len_err;

  always_comb begin
    // Restart clears the parser ahead of this byte
    if (restart) begin
      s.ps         = PS_SIZE;
      s.size_acc   = '0;
      s.chunk_left = '0;
      s.consumed   = '0;
      s.emitted    = '0;
    end else begin
      s = cur;
    end

    hex      = hex_decode(byte_in);
    left_dec = s.chunk_left - SIZE_BITS'(1);
    emit_inc = s.emitted + COUNT_BITS'(1);
    cons_inc = s.consumed + COUNT_BITS'(1);
    len_err  = (s.ps == PS_ERR) || (cfg.body_len > BODY_CAP) ||
               (s.consumed >= cfg.body_len) || (s.emitted >= cfg.max_output);

    nxt  = s;
    emit = 1'b0;
    res.status = STAT_NOFRAME;

    if (cfg.framing_mode == MODE_LENGTH) begin
      // Fixed length: pass through until content length is reached
      if (len_err) begin
        nxt.ps     = PS_ERR;
        res.status = STAT_ERROR;
      end else begin
        emit         = 1'b1;
        nxt.emitted  = emit_inc;
        nxt.consumed = cons_inc;
        res.status   = (cons_inc < cfg.body_len) ? STAT_MORE : STAT_COMPLETE;
      end
    end else if (cfg.framing_mode == MODE_CHUNKED) begin
      // Saturating byte count
      if (s.consumed != COUNT_MAX) nxt.consumed = cons_inc;

      unique case (s.ps)
        PS_SIZE: begin
          if (hex[4]) begin
            if (s.size_acc[SIZE_BITS-1 -: 4] != 4'd0) nxt.ps = PS_ERR;
            else nxt.size_acc = {s.size_acc[SIZE_BITS-5:0], hex[3:0]};
          end else if (byte_in == CH_SEMI) begin
            nxt.ps = PS_EXT;
          end else if (byte_in == CH_CR) begin
            nxt.ps = PS_SIZE_LF;
          end else begin
            nxt.ps = PS_ERR;
          end
        end
        PS_EXT: begin
          if (byte_in == CH_CR) nxt.ps = PS_SIZE_LF;
          else if (byte_in == CH_LF) nxt.ps = PS_ERR;
        end
        PS_SIZE_LF: begin
          if (byte_in != CH_LF) begin
            nxt.ps = PS_ERR;
          end else if (s.size_acc == '0) begin
            nxt.ps = PS_TR_START;
          end else begin
            nxt.chunk_left = s.size_acc;
            nxt.ps         = PS_DATA;
          end
        end
        PS_DATA: begin
          if (s.emitted >= cfg.max_output) begin
            nxt.ps = PS_ERR;
          end else begin
            emit           = 1'b1;
            nxt.emitted    = emit_inc;
            nxt.chunk_left = left_dec;
            if (left_dec == '0) nxt.ps = PS_DATA_END;
          end
        end
        PS_DATA_END: begin
          if (byte_in == CH_LF) begin
            nxt.size_acc = '0;
            nxt.ps       = PS_SIZE;
          end else if (byte_in != CH_CR) begin
            nxt.ps = PS_ERR;
          end
        end
        PS_TR_START: begin
          if (byte_in == CH_CR) nxt.ps = PS_TR_FINAL_LF;
          else if (is_name_start(byte_in)) nxt.ps = PS_TR_LINE;
          else nxt.ps = PS_ERR;
        end
        PS_TR_LINE: begin
          if (byte_in == CH_CR) nxt.ps = PS_TR_LF;
          else if (byte_in < CH_SPACE || byte_in == CH_DEL) nxt.ps = PS_ERR;
        end
        PS_TR_LF:       nxt.ps = (byte_in == CH_LF) ? PS_TR_START : PS_ERR;
        PS_TR_FINAL_LF: nxt.ps = (byte_in == CH_LF) ? PS_DONE : PS_ERR;
        default:        nxt.ps = PS_ERR;
      endcase

      if (nxt.ps == PS_ERR) res.status = STAT_ERROR;
      else if (nxt.ps == PS_DONE) res.status = STAT_COMPLETE;
      else res.status = STAT_MORE;
    end

    res.payload_valid = emit;
    res.payload_byte  = emit ? byte_in : 8'd0;
  end

endmodule

/* rtl/http_body_chunked_decoder.sv */
// HTTP/1.1 body decoder top level: configuration registers, input and result registers.
// Depends on hbcd_pkg and hbcd_step.
//
// Takes one body byte per request and returns exactly one result per byte, one byte
// per clock cycle sustained while out_tready stays high. A byte is registered in the
// input register on acceptance, decoded by hbcd_step from there, and moves with the
// parser state update into the result register once it is free. The input side keeps
// accepting while a result waits on out_tready, until both the input register and the
// result register are full. No clearing pass is needed after reset. The user must write
// configuration only while no byte is in flight; the block itself does not enforce it.
module http_body_chunked_decoder (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [7:0] in_byte
  input  logic                             in_tuser,   // [0] restart
  input  logic                             in_tlast,   // buffer_end
  // Result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [7:0]                       out_tdata,  // [7:0] payload_byte
  output logic [2:0]                       out_tuser,  // [0] payload_valid, [2:1] status
  output logic                             out_tlast,  // end_marker
  // Configuration write port
  input  logic                             cfg_we,
  input  logic [hbcd_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [hbcd_pkg::CFG_W-1:0]       cfg_wdata
);
  import hbcd_pkg::*;

  cfg_t       cfg_r;
  parser_t    parser_r;
  parser_t    parser_nxt;
  result_t    res_nxt;

  logic       stg_valid_r;
  logic [7:0] stg_byte_r;
  logic       stg_restart_r;
  logic       stg_last_r;

  logic       out_valid_r;
  result_t    out_res_r;
  logic       out_last_r;

  logic       in_req;
  logic       advance;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !stg_valid_r || advance;
  assign in_req    = in_tvalid && in_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.framing_mode <= MODE_NONE;
      cfg_r.body_len     <= '0;
      cfg_r.max_output   <= {CFG_W{1'b1}};
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FRAMING_MODE: cfg_r.framing_mode <= cfg_wdata[1:0];
        REG_BODY_LEN:     cfg_r.body_len     <= cfg_wdata;
        REG_MAX_OUTPUT:   cfg_r.max_output   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register: take a new request whenever the stage frees up
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_req) begin
      stg_valid_r <= 1'b1;
    end else if (advance) begin
      stg_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_req) begin
      stg_byte_r    <= in_tdata;
      stg_restart_r <= in_tuser;
      stg_last_r    <= in_tlast;
    end
  end

  hbcd_step u_step (
    .cur     (parser_r),
    .cfg     (cfg_r),
    .byte_in (stg_byte_r),
    .restart (stg_restart_r),
    .nxt     (parser_nxt),
    .res     (res_nxt)
  );

  // Parser state advances as the staged byte moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parser_r.ps         <= PS_SIZE;
      parser_r.size_acc   <= '0;
      parser_r.chunk_left <= '0;
      parser_r.consumed   <= '0;
      parser_r.emitted    <= '0;
    end else if (stg_valid_r && advance) begin
      parser_r <= parser_nxt;
    end
  end

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stg_valid_r && advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_valid_r && advance) begin
      out_res_r  <= res_nxt;
      out_last_r <= stg_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.payload_byte;
  assign out_tuser  = {out_res_r.status, out_res_r.payload_valid};
  assign out_tlast  = out_last_r;

endmodule

/* test/tb_http_body_chunked_decoder.sv */
`timescale 1ns / 1ps
// Testbench for http_body_chunked_decoder: feeds body byte requests in all framing modes
// and checks every result field against a decoder model kept inside the bench.
// Depends on hbcd_pkg and the decoder RTL only.
module tb_http_body_chunked_decoder;
  import hbcd_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_STALL  = 80;
  localparam logic [SIZE_BITS-1:0] SIZE_GUARD = {SIZE_BITS{1'b1}} >> 4;

  typedef struct packed {
    logic [7:0] data;
    logic       restart;
    logic       bend;
  } body_req_t;

  typedef struct packed {
    logic       pv;
    logic [7:0] data;
    logic [1:0] status;
    logic       emark;
  } body_res_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata   = 8'h00;
  logic                 in_tuser   = 1'b0;
  logic                 in_tlast   = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;
  logic [2:0]           out_tuser;
  logic                 out_tlast;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr   = '0;
  logic [CFG_W-1:0]     cfg_wdata  = '0;

  always #6 clk = ~clk;

  http_body_chunked_decoder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // Decoder model: configuration copy and parser state
  logic [1:0]            cfg_mode     = MODE_NONE;
  logic [CFG_W-1:0]      cfg_clen     = '0;
  logic [CFG_W-1:0]      cfg_maxo     = {CFG_W{1'b1}};
  pstate_t               mdl_ps       = PS_SIZE;
  logic [SIZE_BITS-1:0]  mdl_size     = '0;
  logic [SIZE_BITS-1:0]  mdl_left     = '0;
  logic [COUNT_BITS-1:0] mdl_consumed = '0;
  logic [COUNT_BITS-1:0] mdl_emitted  = '0;

  // Request queue, pending results and bookkeeping
  body_req_t   pend_q[$];
  body_res_t   result_q[$];
  logic [7:0]  msg_q[$];
  body_req_t   on_bus;
  int unsigned n_queued   = 0;
  int unsigned n_accepted = 0;
  int unsigned n_fail     = 0;
  int          src_pct    = 0;
  int          sink_pct   = 0;
  int          src_gap    = 0;
  int          sink_hold  = 0;
  int          stall_req  = 0;
  int          stall_ack  = 0;
  int          quiet      = 0;

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic logic token_start(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           (c >= "0" && c <= "9") || c == "-" || c == "_";
  endfunction

  // Work out the result of one accepted request and advance the model
  function automatic body_res_t decode_byte(input body_req_t r);
    body_res_t res;
    logic      emit;
    int        d;
    emit = 1'b0;
    res.status = STAT_NOFRAME;
    if (r.restart) begin
      mdl_ps = PS_SIZE;
      mdl_size = '0;
      mdl_left = '0;
      mdl_consumed = '0;
      mdl_emitted = '0;
    end
    if (cfg_mode == MODE_LENGTH) begin
      if (mdl_ps == PS_ERR || cfg_clen > BODY_CAP || mdl_consumed >= cfg_clen ||
          mdl_emitted >= cfg_maxo) begin
        mdl_ps = PS_ERR;
        res.status = STAT_ERROR;
      end else begin
        emit = 1'b1;
        mdl_emitted++;
        mdl_consumed++;
        res.status = (mdl_consumed < cfg_clen) ? STAT_MORE : STAT_COMPLETE;
      end
    end else if (cfg_mode == MODE_CHUNKED) begin
      if (mdl_consumed != COUNT_MAX) mdl_consumed++;
      d = hex_digit(r.data);
      case (mdl_ps)
        PS_SIZE: begin
          if (d >= 0) begin
            // refuse a digit that would push the size past the accumulator
            if (mdl_size > SIZE_GUARD) mdl_ps = PS_ERR;
            else mdl_size = {mdl_size[SIZE_BITS-5:0], 4'(d)};
          end else if (r.data == CH_SEMI) mdl_ps = PS_EXT;
          else if (r.data == CH_CR) mdl_ps = PS_SIZE_LF;
          else mdl_ps = PS_ERR;
        end
        PS_EXT: begin
          if (r.data == CH_CR) mdl_ps = PS_SIZE_LF;
          else if (r.data == CH_LF) mdl_ps = PS_ERR;
        end
        PS_SIZE_LF: begin
          if (r.data != CH_LF) mdl_ps = PS_ERR;
          else if (mdl_size == '0) mdl_ps = PS_TR_START;
          else begin
            mdl_left = mdl_size;
            mdl_ps = PS_DATA;
          end
        end
        PS_DATA: begin
          if (mdl_emitted >= cfg_maxo) mdl_ps = PS_ERR;
          else begin
            emit = 1'b1;
            mdl_emitted++;
            mdl_left--;
            if (mdl_left == '0) mdl_ps = PS_DATA_END;
          end
        end
        PS_DATA_END: begin
          if (r.data == CH_LF) begin
            mdl_size = '0;
            mdl_ps = PS_SIZE;
          end else if (r.data != CH_CR) mdl_ps = PS_ERR;
        end
        PS_TR_START: begin
          if (r.data == CH_CR) mdl_ps = PS_TR_FINAL_LF;
          else if (token_start(r.data)) mdl_ps = PS_TR_LINE;
          else mdl_ps = PS_ERR;
        end
        PS_TR_LINE: begin
          if (r.data == CH_CR) mdl_ps = PS_TR_LF;
          else if (r.data < CH_SPACE || r.data == CH_DEL) mdl_ps = PS_ERR;
        end
        PS_TR_LF:       mdl_ps = (r.data == CH_LF) ? PS_TR_START : PS_ERR;
        PS_TR_FINAL_LF: mdl_ps = (r.data == CH_LF) ? PS_DONE : PS_ERR;
        default:        mdl_ps = PS_ERR;
      endcase
      if (mdl_ps == PS_ERR) res.status = STAT_ERROR;
      else if (mdl_ps == PS_DONE) res.status = STAT_COMPLETE;
      else res.status = STAT_MORE;
    end
    res.pv = emit;
    res.data = emit ? r.data : 8'h00;
    res.emark = r.bend;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    n_fail++;
  endtask

  task automatic check_result();
    body_res_t want;
    if (result_q.size() == 0) begin
      report_mismatch("unrequested result", 0, {out_tlast, out_tuser, out_tdata});
    end else begin
      want = result_q.pop_front();
      if (out_tuser[0] !== want.pv) report_mismatch("payload_valid", want.pv, out_tuser[0]);
      if (out_tdata !== want.data) report_mismatch("payload_byte", want.data, out_tdata);
      if (out_tuser[2:1] !== want.status)
        report_mismatch("status", want.status, out_tuser[2:1]);
      if (out_tlast !== want.emark) report_mismatch("end_marker", want.emark, out_tlast);
    end
  endtask

  // Request driver: hold while stalled, otherwise gap or launch the next request
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        result_q.push_back(decode_byte(on_bus));
        n_accepted++;
        if (src_pct != 0 && $urandom_range(0, 99) < src_pct) src_gap = $urandom_range(1, 18);
      end
      if (in_tvalid && !in_tready) begin
        // hold the request on the bus
      end else if (src_gap > 0) begin
        src_gap--;
        in_tvalid <= 1'b0;
      end else if (pend_q.size() != 0) begin
        on_bus = pend_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= on_bus.data;
        in_tuser <= on_bus.restart;
        in_tlast <= on_bus.bend;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result monitor and receiver backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_result();
      if (stall_ack != stall_req) begin
        stall_ack = stall_req;
        sink_hold = LONG_STALL;
      end
      if (sink_hold > 0) begin
        sink_hold--;
        out_tready <= 1'b0;
      end else if (sink_pct != 0 && $urandom_range(0, 99) < sink_pct) begin
        sink_hold = $urandom_range(0, 17);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no handshake happens for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic rs, input logic be);
    body_req_t r;
    r.data = b;
    r.restart = rs;
    r.bend = be;
    pend_q.push_back(r);
    n_queued++;
  endtask

  task automatic push_text(input string s, input logic rs);
    int i;
    for (i = 0; i < s.len(); i++) push_byte(s[i], rs && i == 0, i == s.len() - 1);
  endtask

  // Move the assembled message into the request queue
  task automatic flush_msg(input logic rs);
    int i;
    for (i = 0; i < msg_q.size(); i++)
      push_byte(msg_q[i], rs && i == 0, $urandom_range(0, 7) == 0);
    msg_q.delete();
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 10) return 8'("0") + nib;
    return ($urandom_range(0, 1) ? 8'("A") : 8'("a")) + nib - 8'd10;
  endfunction

  function automatic logic [7:0] special_byte();
    case ($urandom_range(0, 4))
      0:       return CH_CR;
      1:       return CH_LF;
      2:       return CH_SEMI;
      3:       return CH_DEL;
      default: return 8'h00;
    endcase
  endfunction

  task automatic add_hex(input int unsigned v);
    int         i;
    logic [3:0] nib;
    logic       lead;
    lead = 1'b0;
    for (i = 7; i >= 0; i--) begin
      nib = v[4*i +: 4];
      if (nib != 0 || lead || i == 0) begin
        lead = 1'b1;
        msg_q.push_back(hex_char(nib));
      end
    end
  endtask

  task automatic add_ext();
    if ($urandom_range(0, 3) == 0) begin
      msg_q.push_back(CH_SEMI);
      repeat ($urandom_range(0, 5)) msg_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
    end
  endtask

  task automatic add_crlf();
    msg_q.push_back(CH_CR);
    msg_q.push_back(CH_LF);
  endtask

  // Well-formed chunked body with random sizes, data, extensions and trailers
  task automatic build_chunked();
    int         sz;
    logic [7:0] c;
    repeat ($urandom_range(0, 3)) begin
      sz = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      if ($urandom_range(0, 5) == 0) msg_q.push_back("0");
      add_hex(sz);
      add_ext();
      add_crlf();
      repeat (sz) msg_q.push_back(8'($urandom_range(0, 255)));
      // data line end: a run of zero to two CRs, then LF
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(0, 2) : 1) msg_q.push_back(CH_CR);
      msg_q.push_back(CH_LF);
    end
    // last chunk, sometimes with an empty size
    if ($urandom_range(0, 3) != 0) msg_q.push_back("0");
    add_ext();
    add_crlf();
    repeat ($urandom_range(0, 2)) begin
      do c = 8'($urandom_range(0, 255)); while (!token_start(c));
      msg_q.push_back(c);
      repeat ($urandom_range(0, 6)) msg_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
      add_crlf();
    end
    add_crlf();
  endtask

  task automatic build_length();
    int n;
    n = (cfg_clen == 0 || cfg_clen > 40) ? $urandom_range(1, 30) : cfg_clen;
    repeat (n) msg_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // Break a message: bad byte, size overflow, bytes after the end, or truncation
  task automatic mutate_msg();
    int pos;
    pos = $urandom_range(0, msg_q.size() - 1);
    case ($urandom_range(0, 4))
      0:       msg_q[pos] = 8'($urandom_range(0, 255));
      1:       msg_q[pos] = special_byte();
      2:       repeat (9) msg_q.push_front(hex_char(4'($urandom_range(1, 15))));
      3:       repeat ($urandom_range(1, 2)) msg_q.push_back(8'($urandom_range(0, 255)));
      default: while (msg_q.size() > pos + 1) void'(msg_q.pop_back());
    endcase
  endtask

  task automatic fill_bodies(input int n);
    int unsigned stop;
    stop = n_queued + n;
    while (n_queued < stop) begin
      if (cfg_mode == MODE_CHUNKED) build_chunked();
      else if (cfg_mode == MODE_LENGTH) build_length();
      else msg_q.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 4) == 0) mutate_msg();
      flush_msg($urandom_range(0, 7) != 0);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FRAMING_MODE: cfg_mode = val[1:0];
      REG_BODY_LEN:     cfg_clen = val;
      REG_MAX_OUTPUT:   cfg_maxo = val;
      default: ;
    endcase
  endtask

  // Wait until every request is taken and every result has come back
  task automatic wait_idle();
    while (n_accepted != n_queued || result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: no framing after reset, extreme bytes
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b1, 1'b1);
    wait_idle();
    // Fixed length of two, then a byte after completion
    write_reg(REG_FRAMING_MODE, CFG_W'(MODE_LENGTH));
    write_reg(REG_BODY_LEN, CFG_W'(2));
    push_text("abc", 1'b1);
    wait_idle();
    // Chunked: extension, CR run after data, empty size line, trailer, byte after end
    write_reg(REG_FRAMING_MODE, CFG_W'(MODE_CHUNKED));
    push_text("1;x\015\012Z\015\015\012\015\012T:1\015\012\015\012!", 1'b1);
    // Size digits past the accumulator
    push_text("123456789", 1'b1);
    wait_idle();

    // Chunked bodies with idling on both sides and one long receiver hold-off
    src_pct = 10;
    sink_pct = 10;
    stall_req++;
    fill_bodies(450);
    wait_idle();

    // Fixed length bodies of several sizes
    src_pct = 25;
    sink_pct = 5;
    write_reg(REG_FRAMING_MODE, CFG_W'(MODE_LENGTH));
    write_reg(REG_BODY_LEN, CFG_W'(1));
    fill_bodies(40);
    wait_idle();
    repeat (4) begin
      write_reg(REG_BODY_LEN, CFG_W'($urandom_range(3, 20)));
      fill_bodies(40);
      wait_idle();
    end

    // Content length extremes and the body cap
    src_pct = 0;
    sink_pct = 30;
    write_reg(REG_BODY_LEN, '0);
    fill_bodies(10);
    wait_idle();
    write_reg(REG_BODY_LEN, BODY_CAP + CFG_W'(1));
    fill_bodies(10);
    wait_idle();
    write_reg(REG_BODY_LEN, {CFG_W{1'b1}});
    fill_bodies(10);
    wait_idle();
    write_reg(REG_BODY_LEN, BODY_CAP);
    fill_bodies(30);
    wait_idle();

    // No output room at all
    write_reg(REG_MAX_OUTPUT, '0);
    write_reg(REG_BODY_LEN, CFG_W'(5));
    fill_bodies(10);
    wait_idle();
    write_reg(REG_FRAMING_MODE, CFG_W'(MODE_CHUNKED));
    fill_bodies(40);
    wait_idle();

    // Small output buffer, overflow inside bodies
    src_pct = 15;
    sink_pct = 15;
    write_reg(REG_MAX_OUTPUT, CFG_W'($urandom_range(5, 20)));
    fill_bodies(150);
    wait_idle();
    write_reg(REG_FRAMING_MODE, CFG_W'(MODE_LENGTH));
    write_reg(REG_BODY_LEN, CFG_W'(12));
    write_reg(REG_MAX_OUTPUT, CFG_W'(5));
    fill_bodies(24);
    wait_idle();

    // No framing and the unused mode
    write_reg(REG_MAX_OUTPUT, {CFG_W{1'b1}});
    write_reg(REG_FRAMING_MODE, CFG_W'(MODE_NONE));
    fill_bodies(30);
    wait_idle();
    write_reg(REG_FRAMING_MODE, CFG_W'(MODE_RESERVED));
    fill_bodies(30);
    wait_idle();

    // Mode change in the middle of a body: parser state carries over
    write_reg(REG_FRAMING_MODE, CFG_W'(MODE_CHUNKED));
    build_chunked();
    while (msg_q.size() > 6) void'(msg_q.pop_back());
    flush_msg(1'b1);
    wait_idle();
    write_reg(REG_BODY_LEN, CFG_W'(6));
    write_reg(REG_FRAMING_MODE, CFG_W'(MODE_LENGTH));
    repeat (4) push_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
    wait_idle();
    write_reg(REG_FRAMING_MODE, CFG_W'(MODE_CHUNKED));
    build_chunked();
    flush_msg(1'b0);
    wait_idle();

    // Final stretch at full rate
    src_pct = 0;
    sink_pct = 0;
    fill_bodies(350);
    wait_idle();

    repeat (8) @(posedge clk);
    if (n_fail == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

/* files.f */
rtl/hbcd_pkg.sv
rtl/hbcd_step.sv
rtl/http_body_chunked_decoder.sv
test/tb_http_body_chunked_decoder.sv
